// ===== rtl/ecbw_pkg.sv =====
// shared constants, register codes and quarter-wave sine table for the auto-wah
`timescale 1ns / 1ps

package ecbw_pkg;

	localparam int SAMPLE_W   = 16;
	localparam int HIST_W     = 20;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	localparam int SAMPLE_RATE = 44100;
	// nyquist in hz, q16
	localparam logic [30:0] FREQ_MAX = 31'(SAMPLE_RATE * 32768);
	// 2^47 / sample rate, phase estimate is freq * this >> 37
	localparam logic [31:0] PH_RECIP = 32'((64'd1 << 47) / 64'(SAMPLE_RATE));

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_SENSITIVITY = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ATTACK      = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_RELEASE     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_FREQ    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_FREQ    = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_RESONANCE   = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_MIX         = 3'd6;

	localparam logic [15:0] RST_SENSITIVITY = 16'd16384;
	localparam logic [15:0] RST_ATTACK      = 16'd65387;
	localparam logic [15:0] RST_RELEASE     = 16'd65521;
	localparam logic [9:0]  RST_MIN_FREQ    = 10'd500;
	localparam logic [13:0] RST_MAX_FREQ    = 14'd3000;
	localparam logic [11:0] RST_RESONANCE   = 12'd512;
	localparam logic [15:0] RST_MIX         = 16'd16384;

	// quarter wave: entry m holds sin(pi/2 * m / 256) in q30
	localparam int QS_W       = 31;
	localparam int QS_ENTRIES = 257;

	typedef logic [QS_W-1:0] qs_tab_t [QS_ENTRIES];

	function automatic longint unsigned qs_sq(input longint unsigned term,
			input longint unsigned x);
		longint unsigned t;
		t = (term * x) >> 30;
		t = (t * x) >> 30;
		return t;
	endfunction

	// taylor series up to the x^13 term on the reduced angle
	function automatic qs_tab_t build_qsine();
		qs_tab_t tab;
		longint unsigned x;
		longint unsigned term;
		longint sum;
		for (int m = 0; m < QS_ENTRIES; m++) begin
			x = (64'd1686629713 * longint'(m)) >> 8;
			term = x;
			sum = longint'(x);
			term = qs_sq(term, x) / 64'd6;
			sum = sum - longint'(term);
			term = qs_sq(term, x) / 64'd20;
			sum = sum + longint'(term);
			term = qs_sq(term, x) / 64'd42;
			sum = sum - longint'(term);
			term = qs_sq(term, x) / 64'd72;
			sum = sum + longint'(term);
			term = qs_sq(term, x) / 64'd110;
			sum = sum - longint'(term);
			term = qs_sq(term, x) / 64'd156;
			sum = sum + longint'(term);
			if (sum < 0) begin
				sum = 0;
			end
			if (sum > 64'sd1073741824) begin
				sum = 64'sd1073741824;
			end
			tab[m] = QS_W'(sum);
		end
		return tab;
	endfunction

	localparam qs_tab_t QS_TABLE = build_qsine();

	// full-wave table entry k of 1024, q30 signed
	function automatic logic signed [31:0] sine_at(input logic [9:0] k);
		logic [8:0] kk;
		logic [8:0] m;
		logic [31:0] mag;
		kk = k[8:0];
		m = (kk <= 9'd256) ? kk : 9'(10'd512 - {1'b0, kk});
		mag = {1'b0, QS_TABLE[m]};
		return k[9] ? signed'(-mag) : signed'(mag);
	endfunction

endpackage

// ===== rtl/envelope_controlled_bandpass_wah.sv =====
// auto-wah top level: envelope follower, swept bandpass biquad and dry/wet mix
// a new sample beat is not taken until the previous frame's result beat is raised;
// the work is set by the shared restoring divider (69 steps per channel)
// and the shared 33x33 multiplier, channels in turn
// reset: async active low, clears sequencer, envelopes and filter history,
// loads the register defaults
`timescale 1ns / 1ps

module envelope_controlled_bandpass_wah (
	input  logic                                     clk,
	input  logic                                     arst_n,
	input  logic                                     cfg_valid,
	output logic                                     cfg_ready,
	input  logic [ecbw_pkg::CFG_IDX_W-1:0]           cfg_index,
	input  logic [ecbw_pkg::CFG_DATA_W-1:0]          cfg_data,
	input  logic                                     sample_valid,
	output logic                                     sample_stall,
	input  logic signed [ecbw_pkg::SAMPLE_W-1:0]     left_sample,
	input  logic signed [ecbw_pkg::SAMPLE_W-1:0]     right_sample,
	input  logic                                     frame_end_in,
	output logic                                     result_valid,
	input  logic                                     result_stall,
	output logic signed [ecbw_pkg::SAMPLE_W-1:0]     left_out,
	output logic signed [ecbw_pkg::SAMPLE_W-1:0]     right_out,
	output logic                                     frame_end_out
);
	import ecbw_pkg::*;

	localparam logic [4:0] ST_IDLE     = 5'd0;
	localparam logic [4:0] ST_ENV_MUL  = 5'd1;
	localparam logic [4:0] ST_ENV_WR   = 5'd2;
	localparam logic [4:0] ST_ES_MUL   = 5'd3;
	localparam logic [4:0] ST_HI_MUL   = 5'd4;
	localparam logic [4:0] ST_LO_MUL   = 5'd5;
	localparam logic [4:0] ST_FSUM     = 5'd6;
	localparam logic [4:0] ST_FCLAMP   = 5'd7;
	localparam logic [4:0] ST_PH_EST   = 5'd8;
	localparam logic [4:0] ST_SIN_A    = 5'd9;
	localparam logic [4:0] ST_SIN_M    = 5'd10;
	localparam logic [4:0] ST_SIN_W    = 5'd11;
	localparam logic [4:0] ST_COS_A    = 5'd12;
	localparam logic [4:0] ST_COS_M    = 5'd13;
	localparam logic [4:0] ST_COS_W    = 5'd14;
	localparam logic [4:0] ST_DIV_AL   = 5'd15;
	localparam logic [4:0] ST_INV_INIT = 5'd16;
	localparam logic [4:0] ST_DIV_INV  = 5'd17;
	localparam logic [4:0] ST_A1_MUL   = 5'd18;
	localparam logic [4:0] ST_B0_MUL   = 5'd19;
	localparam logic [4:0] ST_P2_MUL   = 5'd20;
	localparam logic [4:0] ST_P3_MUL   = 5'd21;
	localparam logic [4:0] ST_Y_WR     = 5'd22;
	localparam logic [4:0] ST_MIX_MUL  = 5'd23;
	localparam logic [4:0] ST_MIX_WR   = 5'd24;
	localparam logic [4:0] ST_OUT      = 5'd25;
	localparam logic [4:0] ST_PH_FIX   = 5'd26;

	localparam logic [5:0] DIV_AL_STEPS  = 6'd38;
	localparam logic [5:0] DIV_INV_STEPS = 6'd31;

	logic [4:0]  st_q;
	logic        ch_q;
	logic [5:0]  cnt_q;

	logic [15:0] sens_q;
	logic [15:0] att_q;
	logic [15:0] rel_q;
	logic [9:0]  minf_q;
	logic [13:0] maxf_q;
	logic [11:0] res_q;
	logic [15:0] mix_q;

	logic signed [15:0] lx_q;
	logic signed [15:0] rx_q;
	logic               fe_q;

	logic [31:0]        env_q [2];
	logic signed [15:0] ih1_q [2];
	logic signed [15:0] ih2_q [2];
	logic signed [19:0] oh1_q [2];
	logic signed [19:0] oh2_q [2];

	logic signed [65:0] prod_q;
	logic [23:0]        plo_q;
	logic signed [63:0] fsum_q;
	logic [37:0]        rem_q;
	logic [37:0]        dd_q;
	logic [63:0]        dnum_q;
	logic [25:0]        phase_q;
	logic signed [31:0] base_q;
	logic signed [31:0] nxt_q;
	logic signed [31:0] sin_q;
	logic signed [31:0] cos_q;
	logic [30:0]        inv_q;
	logic signed [32:0] a1_q;
	logic signed [54:0] acc_q;
	logic signed [19:0] y_q;
	logic signed [15:0] wl_q;
	logic signed [15:0] wr_q;

	logic signed [15:0] lo_q;
	logic signed [15:0] ro_q;
	logic               feo_q;
	logic               rv_q;

	logic signed [15:0] x_cur;
	logic [15:0]        mag;
	logic [31:0]        lvl;
	logic [31:0]        env_cur;
	logic               env_up;
	logic [31:0]        env_diff;
	logic [31:0]        env_next;
	logic signed [14:0] span;
	logic signed [35:0] freq_raw;
	logic [30:0]        freq_cl;
	logic [25:0]        ph_est;
	logic               ph_lo;
	logic [38:0]        div_t;
	logic               div_ge;
	logic [37:0]        div_rem;
	logic [25:0]        ph_sel;
	logic [9:0]         rom_i;
	logic [9:0]         rom_j;
	logic [33:0]        interp;
	logic [30:0]        s_cl;
	logic [11:0]        r_eff;
	logic [30:0]        b0;
	logic signed [32:0] a2;
	logic signed [16:0] xd;
	logic signed [54:0] acc_f;
	logic signed [54:0] acc_r;
	logic signed [24:0] y_rnd;
	logic signed [19:0] y_sat;
	logic signed [20:0] md;
	logic signed [37:0] mix_r;
	logic signed [22:0] mix_o;
	logic signed [15:0] mix_sat;
	logic signed [32:0] mul_a;
	logic signed [32:0] mul_b;
	logic               out_free;

	assign cfg_ready     = 1'b1;
	assign sample_stall  = (st_q != ST_IDLE);
	assign result_valid  = rv_q;
	assign left_out      = lo_q;
	assign right_out     = ro_q;
	assign frame_end_out = feo_q;
	assign out_free      = !rv_q || !result_stall;

	// envelope follower
	assign x_cur    = ch_q ? rx_q : lx_q;
	assign mag      = x_cur[15] ? 16'(-x_cur) : 16'(x_cur);
	assign lvl      = {mag, 16'd0};
	assign env_cur  = env_q[ch_q];
	assign env_up   = lvl > env_cur;
	assign env_diff = env_up ? (lvl - env_cur) : (env_cur - lvl);
	assign env_next = env_up ? (lvl - prod_q[47:16]) : (lvl + prod_q[47:16]);

	// centre frequency, hz in q16
	assign span     = signed'(15'({1'b0, maxf_q}) - 15'(minf_q));
	assign freq_raw = signed'({10'd0, minf_q, 16'd0}) + {{2{fsum_q[63]}}, fsum_q[63:30]};

	always_comb begin
		if (freq_raw[35]) begin
			freq_cl = '0;
		end else if (freq_raw > signed'({5'd0, FREQ_MAX})) begin
			freq_cl = FREQ_MAX;
		end else begin
			freq_cl = freq_raw[30:0];
		end
	end

	// table phase by reciprocal multiply, low by at most one
	assign ph_est = prod_q[62:37];
	assign ph_lo  = (prod_q[40:0] <= {freq_cl, 10'd0});

	// restoring divider step, quotient shifts into the bottom of dnum_q
	assign div_t   = {rem_q, dnum_q[63]};
	assign div_ge  = div_t >= {1'b0, dd_q};
	assign div_rem = div_ge ? 38'(div_t - {1'b0, dd_q}) : div_t[37:0];

	// sine table, cosine is a quarter turn ahead
	assign ph_sel = (st_q == ST_SIN_A) ? dnum_q[25:0] : (phase_q + 26'(1 << 24));
	assign rom_i  = ph_sel[25:16];
	assign rom_j  = rom_i + 10'd1;
	assign interp = {{2{base_q[31]}}, base_q} + 34'(prod_q[49:16]);

	assign s_cl  = sin_q[31] ? 31'd0 : sin_q[30:0];
	assign r_eff = (res_q == 12'd0) ? 12'd1 : res_q;

	// biquad
	assign b0    = 31'(1 << 30) - inv_q;
	assign a2    = signed'({1'b0, inv_q, 1'b0}) - 33'sd1073741824;
	assign xd    = 17'(x_cur) - 17'(ih2_q[ch_q]);
	assign acc_f = acc_q - prod_q[54:0];
	assign acc_r = acc_f + 55'sd536870912;
	assign y_rnd = acc_r[54:30];

	always_comb begin
		if (y_rnd > 25'sd524287) begin
			y_sat = 20'sd524287;
		end else if (y_rnd < -25'sd524288) begin
			y_sat = -20'sd524288;
		end else begin
			y_sat = y_rnd[19:0];
		end
	end

	// dry/wet crossfade
	assign md    = 21'(y_q) - 21'(x_cur);
	assign mix_r = prod_q[37:0] + 38'sd16384;
	assign mix_o = mix_r[37:15] + 23'(x_cur);

	always_comb begin
		if (mix_o > 23'sd32767) begin
			mix_sat = 16'sd32767;
		end else if (mix_o < -23'sd32768) begin
			mix_sat = -16'sd32768;
		end else begin
			mix_sat = mix_o[15:0];
		end
	end

	// operands of the shared multiplier
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (st_q)
			ST_ENV_MUL: begin
				mul_a = signed'({1'b0, env_diff});
				mul_b = signed'({17'd0, env_up ? att_q : rel_q});
			end
			ST_ES_MUL: begin
				mul_a = signed'({1'b0, env_cur});
				mul_b = signed'({17'd0, sens_q});
			end
			ST_HI_MUL: begin
				mul_a = 33'(span);
				mul_b = signed'({9'd0, prod_q[47:24]});
			end
			ST_LO_MUL: begin
				mul_a = 33'(span);
				mul_b = signed'({9'd0, plo_q});
			end
			ST_FCLAMP: begin
				mul_a = signed'({2'd0, freq_cl});
				mul_b = signed'({1'b0, PH_RECIP});
			end
			ST_PH_EST: begin
				mul_a = signed'({7'd0, ph_est + 26'd1});
				mul_b = 33'(SAMPLE_RATE);
			end
			ST_SIN_M, ST_COS_M: begin
				mul_a = 33'(nxt_q) - 33'(base_q);
				mul_b = signed'({17'd0, phase_q[15:0]});
			end
			ST_A1_MUL: begin
				mul_a = 33'(cos_q);
				mul_b = signed'({2'd0, dnum_q[30:0]});
			end
			ST_B0_MUL: begin
				mul_a = signed'({2'd0, b0});
				mul_b = 33'(xd);
			end
			ST_P2_MUL: begin
				mul_a = a1_q;
				mul_b = 33'(oh1_q[ch_q]);
			end
			ST_P3_MUL: begin
				mul_a = a2;
				mul_b = 33'(oh2_q[ch_q]);
			end
			ST_MIX_MUL: begin
				mul_a = 33'(md);
				mul_b = signed'({17'd0, mix_q});
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sens_q <= RST_SENSITIVITY;
			att_q  <= RST_ATTACK;
			rel_q  <= RST_RELEASE;
			minf_q <= RST_MIN_FREQ;
			maxf_q <= RST_MAX_FREQ;
			res_q  <= RST_RESONANCE;
			mix_q  <= RST_MIX;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_SENSITIVITY: sens_q <= cfg_data;
				REG_ATTACK:      att_q  <= cfg_data;
				REG_RELEASE:     rel_q  <= cfg_data;
				REG_MIN_FREQ:    minf_q <= cfg_data[9:0];
				REG_MAX_FREQ:    maxf_q <= cfg_data[13:0];
				REG_RESONANCE:   res_q  <= cfg_data[11:0];
				REG_MIX:         mix_q  <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// sequencer and channel state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q  <= ST_IDLE;
			ch_q  <= 1'b0;
			cnt_q <= '0;
			rv_q  <= 1'b0;
			for (int i = 0; i < 2; i++) begin
				env_q[i] <= '0;
				ih1_q[i] <= '0;
				ih2_q[i] <= '0;
				oh1_q[i] <= '0;
				oh2_q[i] <= '0;
			end
		end else begin
			if (rv_q && !result_stall) begin
				rv_q <= 1'b0;
			end
			unique case (st_q)
				ST_IDLE: begin
					if (sample_valid) begin
						st_q <= ST_ENV_MUL;
						ch_q <= 1'b0;
					end
				end
				ST_ENV_MUL: st_q <= ST_ENV_WR;
				ST_ENV_WR: begin
					env_q[ch_q] <= env_next;
					st_q <= ST_ES_MUL;
				end
				ST_ES_MUL: st_q <= ST_HI_MUL;
				ST_HI_MUL: st_q <= ST_LO_MUL;
				ST_LO_MUL: st_q <= ST_FSUM;
				ST_FSUM:   st_q <= ST_FCLAMP;
				ST_FCLAMP: st_q <= ST_PH_EST;
				ST_PH_EST: st_q <= ST_PH_FIX;
				ST_PH_FIX: st_q <= ST_SIN_A;
				ST_SIN_A: st_q <= ST_SIN_M;
				ST_SIN_M: st_q <= ST_SIN_W;
				ST_SIN_W: st_q <= ST_COS_A;
				ST_COS_A: st_q <= ST_COS_M;
				ST_COS_M: st_q <= ST_COS_W;
				ST_COS_W: begin
					cnt_q <= DIV_AL_STEPS;
					st_q  <= ST_DIV_AL;
				end
				ST_DIV_AL: begin
					cnt_q <= cnt_q - 6'd1;
					if (cnt_q == 6'd1) begin
						st_q <= ST_INV_INIT;
					end
				end
				ST_INV_INIT: begin
					cnt_q <= DIV_INV_STEPS;
					st_q  <= ST_DIV_INV;
				end
				ST_DIV_INV: begin
					cnt_q <= cnt_q - 6'd1;
					if (cnt_q == 6'd1) begin
						st_q <= ST_A1_MUL;
					end
				end
				ST_A1_MUL: st_q <= ST_B0_MUL;
				ST_B0_MUL: st_q <= ST_P2_MUL;
				ST_P2_MUL: st_q <= ST_P3_MUL;
				ST_P3_MUL: st_q <= ST_Y_WR;
				ST_Y_WR: begin
					ih2_q[ch_q] <= ih1_q[ch_q];
					ih1_q[ch_q] <= x_cur;
					oh2_q[ch_q] <= oh1_q[ch_q];
					oh1_q[ch_q] <= y_sat;
					st_q <= ST_MIX_MUL;
				end
				ST_MIX_MUL: st_q <= ST_MIX_WR;
				ST_MIX_WR: begin
					if (ch_q) begin
						st_q <= ST_OUT;
					end else begin
						ch_q <= 1'b1;
						st_q <= ST_ENV_MUL;
					end
				end
				ST_OUT: begin
					// hold until the previous result beat has left
					if (out_free) begin
						rv_q <= 1'b1;
						ch_q <= 1'b0;
						st_q <= ST_IDLE;
					end
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		unique case (st_q)
			ST_IDLE: begin
				if (sample_valid) begin
					lx_q <= left_sample;
					rx_q <= right_sample;
					fe_q <= frame_end_in;
				end
			end
			ST_HI_MUL: plo_q <= prod_q[23:0];
			ST_LO_MUL: fsum_q <= {prod_q[39:0], 24'd0};
			ST_FSUM:   fsum_q <= fsum_q + prod_q[63:0];
			ST_PH_EST: dnum_q <= {38'd0, ph_est};
			ST_PH_FIX: begin
				if (ph_lo) begin
					dnum_q <= dnum_q + 64'd1;
				end
			end
			ST_DIV_AL, ST_DIV_INV: begin
				rem_q  <= div_rem;
				dnum_q <= {dnum_q[62:0], div_ge};
			end
			ST_SIN_A: begin
				phase_q <= dnum_q[25:0];
				base_q  <= sine_at(rom_i);
				nxt_q   <= sine_at(rom_j);
			end
			ST_SIN_W: sin_q <= interp[31:0];
			ST_COS_A: begin
				base_q <= sine_at(rom_i);
				nxt_q  <= sine_at(rom_j);
			end
			ST_COS_W: begin
				cos_q  <= interp[31:0];
				// alpha = sin * 128 / q
				rem_q  <= '0;
				dnum_q <= {s_cl, 7'd0, 26'd0};
				dd_q   <= {26'd0, r_eff};
			end
			ST_INV_INIT: begin
				// 2^60 / (1 + alpha)
				rem_q  <= 38'(1 << 29);
				dd_q   <= 38'(1 << 30) + dnum_q[37:0];
				dnum_q <= '0;
			end
			ST_A1_MUL: inv_q <= dnum_q[30:0];
			ST_B0_MUL: a1_q <= -prod_q[61:29];
			ST_P2_MUL: acc_q <= prod_q[54:0];
			ST_P3_MUL: acc_q <= acc_q - prod_q[54:0];
			ST_Y_WR:   y_q <= y_sat;
			ST_MIX_WR: begin
				if (ch_q) begin
					wr_q <= mix_sat;
				end else begin
					wl_q <= mix_sat;
				end
			end
			ST_OUT: begin
				if (out_free) begin
					lo_q  <= wl_q;
					ro_q  <= wr_q;
					feo_q <= fe_q;
				end
			end
			default: begin
			end
		endcase
	end

`ifndef SYNTH
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(sample_valid && !sample_stall) |=> sample_stall)
		else $error("sample beat taken but sequencer did not go busy");

	a_result_from_out: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> $past(st_q == ST_OUT))
		else $error("result beat raised outside the output step");

	a_idle_left: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_IDLE) |-> !ch_q)
		else $error("idle with right channel selected");

	a_div_count: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_DIV_AL || st_q == ST_DIV_INV) |-> (cnt_q != 6'd0))
		else $error("divider running with empty step count");
`endif

endmodule
